@@ hw/rtl/ucbs_pkg.sv @@
// ----------------------------------------------------------------------------
// ucbs_pkg
// shared constants, types and arithmetic helpers of the uniform cubic
// b-spline evaluator
// ----------------------------------------------------------------------------
package ucbs_pkg;

   // default number of control point slots
   localparam int MAX_POINTS_DEF = 16;

   // reset value of the knot interval, about 0.1 s in unsigned q16.16
   localparam logic [31:0] KNOT_RESET = 32'd6554;

   // long division of query_time * 2^16 by the interval, one bit per stage
   localparam int DIV_STEPS = 48;
   localparam int FRAC_W    = 16;

   // one in q0.16 for the local parameter
   localparam logic [16:0] ONE_Q16 = 17'h1_0000;

   // weight scaling: round(w / (6 * 2^16)) = floor((w + 3 * 2^16) / 2^17 / 3)
   localparam logic [51:0] W_BIAS  = 52'd196608;
   localparam int          W_SHIFT = 17;

   // floor(x / 3) as (x * ceil(2^35 / 3)) >> 35, exact for x below 2^35
   localparam logic [33:0] DIV3_MUL   = 34'd11453246123;
   localparam int          DIV3_SHIFT = 35;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_KNOT_INTERVAL = 1'b0,
      CSR_POINT_COUNT   = 1'b1
   } csr_index_type;

   // how the result of an evaluate is formed
   typedef enum logic [1:0] {
      MODE_ZERO,
      MODE_FIRST,
      MODE_BLEND
   } mode_type;

   // one stage of the divider pipeline; loads ride along with their point
   typedef struct packed {
      logic                   vld;
      logic                   act;
      logic [3:0]             idx;
      logic [95:0]            pt;
      logic [31:0]            dvd;
      logic [31:0]            rem;
      logic [DIV_STEPS-1:0]   quo;
   } div_stage_type;

   // result of one restoring division step
   typedef struct packed {
      logic [31:0] rem;
      logic        qbit;
   } div_step_type;

   // control that travels beside the weight and blend stages
   typedef struct packed {
      logic        vld;
      mode_type    mode;
      logic [3:0]  seg;
      logic [95:0] p0;
   } side_type;

   // shift in one dividend bit, subtract the divisor when it fits
   function automatic div_step_type div_step(input logic [31:0] rem,
                                             input logic        bit_in,
                                             input logic [31:0] dvs);
      logic [32:0]  trial;
      div_step_type res;
      trial = {rem, bit_in};
      if (trial >= {1'b0, dvs}) begin
         res.rem  = 32'(trial - {1'b0, dvs});
         res.qbit = 1'b1;
      end else begin
         res.rem  = trial[31:0];
         res.qbit = 1'b0;
      end
      return res;
   endfunction

   // floor(x / 3) by reciprocal multiplication
   function automatic logic [32:0] div3(input logic [33:0] x);
      logic [67:0] prod;
      prod = 68'(x) * 68'(DIV3_MUL);
      return 33'(prod >> DIV3_SHIFT);
   endfunction

endpackage

@@ hw/rtl/uniform_cubic_bspline_eval_top.sv @@
// ----------------------------------------------------------------------------
// uniform_cubic_bspline_eval_top
// pipelined uniform cubic b-spline evaluator over banked control point memory
// ----------------------------------------------------------------------------
// usage
//   csr channel: index 0 knot interval (unsigned q16.16), index 1 point count.
//     always ready; write only while no request is in flight.
//   req channel: action 0 loads point_x/y/z into slot point_index, no response.
//     action 1 evaluates the curve at query_time and gives one rsp.
//   rsp channel: pos_x/y/z in signed q16.16, saturated, and the segment used.
// throughput and pipeline
//   a request enters every cycle while rsp is not stalled. an evaluate passes
//   through 48 stages of bit-serial division for segment and local parameter,
//   the first loaded by the edge that takes it, then one stage of memory read,
//   seven of weight and blend arithmetic, and the output register. the control
//   points sit in four one-port-read banks, one per residue of the slot index
//   mod 4, so the four points of a segment come out in one read. loads write
//   at the read stage, so loads and evaluates see the store in request order.
// reset and stall
//   reset empties the pipeline and restores the registers; the point store is
//   not cleared and slots are undefined until loaded. when rsp is stalled the
//   whole pipeline holds and req_ready falls.
// ----------------------------------------------------------------------------
module uniform_cubic_bspline_eval_top #(
   parameter int MAX_POINTS = ucbs_pkg::MAX_POINTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_action,
   input  logic [3:0]             req_point_index,
   input  logic signed [31:0]     req_point_x,
   input  logic signed [31:0]     req_point_y,
   input  logic signed [31:0]     req_point_z,
   input  logic [31:0]            req_query_time,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [31:0]     rsp_pos_x,
   output logic signed [31:0]     rsp_pos_y,
   output logic signed [31:0]     rsp_pos_z,
   output logic [3:0]             rsp_segment_used,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  ucbs_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_wdata
);
   import ucbs_pkg::*;

   localparam int BANK_DEPTH = (MAX_POINTS + 3) / 4;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int SEG_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int SIDE_N     = 7;
   localparam int PT_N       = 5;

   // configuration registers
   logic [31:0] knot_interval_ff;
   logic [4:0]  point_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         knot_interval_ff <= KNOT_RESET;
         point_count_ff   <= 5'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KNOT_INTERVAL: knot_interval_ff <= csr_wdata;
            CSR_POINT_COUNT:   point_count_ff   <= csr_wdata[4:0];
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // effective interval and count
   logic [31:0]      iv_eff;
   logic [CNT_W-1:0] n_eff;
   logic [31:0]      max_seg;

   always_comb begin
      iv_eff = (knot_interval_ff == 32'd0) ? 32'd1 : knot_interval_ff;
      if (32'(point_count_ff) > 32'(MAX_POINTS)) begin
         n_eff = CNT_W'(MAX_POINTS);
      end else begin
         n_eff = CNT_W'(point_count_ff);
      end
      max_seg = 32'(n_eff) - 32'd4;
   end

   // global advance: the pipeline moves unless the output is held
   logic rsp_valid_ff;
   logic en;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // divider pipeline
   div_stage_type dv_ff [DIV_STEPS];
   div_stage_type dv_in [DIV_STEPS];

   always_comb begin
      div_stage_type src;
      div_step_type  step;
      for (int j = 0; j < DIV_STEPS; j++) begin
         if (j == 0) begin
            src.vld = req_valid;
            src.act = req_action;
            src.idx = req_point_index;
            src.pt  = {req_point_x, req_point_y, req_point_z};
            src.dvd = req_query_time;
            src.rem = 32'd0;
            src.quo = '0;
         end else begin
            src = dv_ff[j-1];
         end
         step        = div_step(src.rem, src.dvd[31], iv_eff);
         dv_in[j]     = src;
         dv_in[j].rem = step.rem;
         dv_in[j].dvd = {src.dvd[30:0], 1'b0};
         dv_in[j].quo = {src.quo[DIV_STEPS-2:0], step.qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DIV_STEPS; j++) begin
            dv_ff[j].vld <= 1'b0;
         end
      end else if (en) begin
         for (int j = 0; j < DIV_STEPS; j++) begin
            dv_ff[j] <= dv_in[j];
         end
      end
   end

   // segment select and clamping at the end of the divider
   div_stage_type    dl;
   logic             a_eval;
   logic             a_load;
   logic [31:0]      a_q;
   mode_type         a_mode_in;
   logic [SEG_W-1:0] a_seg_in;
   logic [16:0]      a_u_in;

   assign dl     = dv_ff[DIV_STEPS-1];
   assign a_eval = dl.vld && dl.act;
   assign a_load = dl.vld && !dl.act;
   assign a_q    = dl.quo[DIV_STEPS-1:FRAC_W];

   always_comb begin
      a_seg_in = '0;
      a_u_in   = 17'd0;
      if (n_eff == CNT_W'(0)) begin
         a_mode_in = MODE_ZERO;
      end else if (32'(n_eff) < 32'd4) begin
         a_mode_in = MODE_FIRST;
      end else begin
         a_mode_in = MODE_BLEND;
         if (a_q > max_seg) begin
            a_seg_in = SEG_W'(max_seg);
            a_u_in   = ONE_Q16;
         end else begin
            a_seg_in = SEG_W'(a_q);
            a_u_in   = {1'b0, dl.quo[FRAC_W-1:0]};
         end
      end
   end

   logic             a_vld_ff;
   mode_type         a_mode_ff;
   logic [SEG_W-1:0] a_seg_ff;
   logic [16:0]      a_u_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= a_eval;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_mode_ff <= a_mode_in;
         a_seg_ff  <= a_seg_in;
         a_u_ff    <= a_u_in;
      end
   end

   // banked point store: slot i lives in bank i mod 4 at row i / 4
   logic [95:0] bank_rd_ff [4];

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [95:0]        bank_mem [BANK_DEPTH];
      logic [1:0]         rd_ofs;
      logic [SEG_W-1:0]   rd_slot;
      logic [BANK_AW-1:0] rd_addr;
      logic [BANK_AW-1:0] wr_addr;
      logic               wr_en;

      // distance from the segment start to the slot of this bank, mod 4
      assign rd_ofs  = 2'(b) - a_seg_in[1:0];
      assign rd_slot = SEG_W'(a_seg_in + SEG_W'(rd_ofs));
      assign rd_addr = BANK_AW'(rd_slot >> 2);
      assign wr_addr = BANK_AW'(dl.idx >> 2);
      assign wr_en   = a_load && (32'(dl.idx) < 32'(MAX_POINTS))
                       && (dl.idx[1:0] == 2'(b));

      always_ff @(posedge clock) begin
         if (en) begin
            if (wr_en) begin
               bank_mem[wr_addr] <= dl.pt;
            end
            bank_rd_ff[b] <= bank_mem[rd_addr];
         end
      end
   end

   // side control and point pipes
   side_type    side_ff [SIDE_N];
   side_type    side_b_in;
   logic [95:0] pt_ff [PT_N][4];
   logic [95:0] pt_b_in [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pt_b_in[k] = bank_rd_ff[2'(a_seg_ff[1:0] + 2'(k))];
      end
      side_b_in.vld  = a_vld_ff;
      side_b_in.mode = a_mode_ff;
      side_b_in.seg  = 4'(a_seg_ff);
      side_b_in.p0   = pt_b_in[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SIDE_N; s++) begin
            side_ff[s].vld <= 1'b0;
         end
      end else if (en) begin
         side_ff[0] <= side_b_in;
         for (int s = 1; s < SIDE_N; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            pt_ff[0][k] <= pt_b_in[k];
            for (int s = 1; s < PT_N; s++) begin
               pt_ff[s][k] <= pt_ff[s-1][k];
            end
         end
      end
   end

   // weight arithmetic
   logic [16:0] b_u_ff, b_v_ff;
   logic [33:0] b_u2_ff, b_v2_ff;
   logic [16:0] c_u_ff;
   logic [33:0] c_u2_ff;
   logic [50:0] c_u3_ff, c_v3_ff;
   logic [33:0] d_x0_ff, d_x2_ff, d_x3_ff;
   logic [32:0] e_w0_ff, e_w2_ff, e_w3_ff;
   logic [32:0] f_w_ff [4];
   logic [51:0] d_w2;
   logic [16:0] a_v;

   assign a_v = ONE_Q16 - a_u_ff;

   // w2 * 6 * 2^16 = 2^48 + 3u 2^32 + 3u^2 2^16 - 3u^3
   always_comb begin
      d_w2 = (52'd1 << 48)
           + ((52'(c_u_ff) * 52'd3) << 32)
           + ((52'(c_u2_ff) * 52'd3) << 16)
           - (52'(c_u3_ff) * 52'd3);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // squares
         b_u_ff  <= a_u_ff;
         b_v_ff  <= a_v;
         b_u2_ff <= 34'(a_u_ff) * 34'(a_u_ff);
         b_v2_ff <= 34'(a_v) * 34'(a_v);
         // cubes
         c_u_ff  <= b_u_ff;
         c_u2_ff <= b_u2_ff;
         c_u3_ff <= 51'(b_u2_ff) * 51'(b_u_ff);
         c_v3_ff <= 51'(b_v2_ff) * 51'(b_v_ff);
         // bias and drop the power-of-two part of the divisor
         d_x0_ff <= 34'((52'(c_v3_ff) + W_BIAS) >> W_SHIFT);
         d_x2_ff <= 34'((d_w2 + W_BIAS) >> W_SHIFT);
         d_x3_ff <= 34'((52'(c_u3_ff) + W_BIAS) >> W_SHIFT);
         // divide by three
         e_w0_ff <= div3(d_x0_ff);
         e_w2_ff <= div3(d_x2_ff);
         e_w3_ff <= div3(d_x3_ff);
         // w1 closes the sum to exactly one
         f_w_ff[0] <= e_w0_ff;
         f_w_ff[1] <= 33'(34'h1_0000_0000 - 34'(e_w0_ff) - 34'(e_w2_ff)
                          - 34'(e_w3_ff));
         f_w_ff[2] <= e_w2_ff;
         f_w_ff[3] <= e_w3_ff;
      end
   end

   // blend: products, pair sums, then round and saturate into the output
   logic signed [65:0] g_prod_ff [3][4];
   logic signed [66:0] h_sum_ff  [3][2];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 4; k++) begin
               g_prod_ff[c][k] <= $signed({1'b0, f_w_ff[k]})
                                  * $signed(pt_ff[PT_N-1][k][95-32*c -: 32]);
            end
            h_sum_ff[c][0] <= 67'(g_prod_ff[c][0]) + 67'(g_prod_ff[c][1]);
            h_sum_ff[c][1] <= 67'(g_prod_ff[c][2]) + 67'(g_prod_ff[c][3]);
         end
      end
   end

   logic signed [31:0] blend_res [3];

   always_comb begin
      logic signed [67:0] total;
      logic signed [33:0] rnd;
      for (int c = 0; c < 3; c++) begin
         total = 68'(h_sum_ff[c][0]) + 68'(h_sum_ff[c][1]);
         rnd   = 34'((total + 68'sd2147483648) >>> 32);
         if (rnd > 34'sd2147483647) begin
            blend_res[c] = 32'sh7FFF_FFFF;
         end else if (rnd < -34'sd2147483648) begin
            blend_res[c] = 32'sh8000_0000;
         end else begin
            blend_res[c] = 32'(rnd);
         end
      end
   end

   // output register
   side_type           sh;
   logic signed [31:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [3:0]         seg_ff;

   assign sh = side_ff[SIDE_N-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sh.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         seg_ff <= sh.seg;
         unique case (sh.mode)
            MODE_ZERO: begin
               pos_x_ff <= '0;
               pos_y_ff <= '0;
               pos_z_ff <= '0;
            end
            MODE_FIRST: begin
               pos_x_ff <= sh.p0[95:64];
               pos_y_ff <= sh.p0[63:32];
               pos_z_ff <= sh.p0[31:0];
            end
            default: begin
               pos_x_ff <= blend_res[0];
               pos_y_ff <= blend_res[1];
               pos_z_ff <= blend_res[2];
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = pos_x_ff;
   assign rsp_pos_y        = pos_y_ff;
   assign rsp_pos_z        = pos_z_ff;
   assign rsp_segment_used = seg_ff;

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the uniform cubic b-spline evaluator: loads control
// points, steps the knot interval and point count through a set of settings,
// and checks every curve position against a cycle-free predictor
// ----------------------------------------------------------------------------
module tb;
   import ucbs_pkg::*;

   // one request as driven on the req channel
   typedef struct {
      logic        action;
      logic [3:0]  idx;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic [31:0] qtime;
   } spline_req_type;

   // one curve position as seen on the rsp channel
   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [3:0]  seg;
   } curve_pos_type;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EVAL = 1'b1;
   localparam int   NPTS     = 16;
   localparam int   SETTLE   = 70;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_action = 1'b0;
   logic [3:0]          req_point_index = '0;
   logic signed [31:0]  req_point_x = '0;
   logic signed [31:0]  req_point_y = '0;
   logic signed [31:0]  req_point_z = '0;
   logic [31:0]         req_query_time = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic signed [31:0]  rsp_pos_x;
   logic signed [31:0]  rsp_pos_y;
   logic signed [31:0]  rsp_pos_z;
   logic [3:0]          rsp_segment_used;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   csr_index_type       csr_index = CSR_KNOT_INTERVAL;
   logic [31:0]         csr_wdata = '0;

   uniform_cubic_bspline_eval_top dut (.*);

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow state of the predictor
   logic [31:0] knot_iv;
   logic [4:0]  pt_count;
   logic [31:0] shx [NPTS];
   logic [31:0] shy [NPTS];
   logic [31:0] shz [NPTS];

   spline_req_type pending_reqs [$];
   curve_pos_type  expected_pos [$];
   int          n_queued = 0;
   int          n_taken = 0;
   int          cyc = 0;
   logic        req_fire = 1'b0;
   bit          failed = 1'b0;

   // blend four points with q0.32 weights, round half up to q16.16
   function automatic logic [31:0] blend_coord(logic [31:0] p [4], logic [63:0] w [4]);
      logic [63:0] acc;
      logic [63:0] r;
      acc = '0;
      for (int k = 0; k < 4; k++)
         acc += w[k] * {{32{p[k][31]}}, p[k]};
      r = ((acc + 64'h8000_0000_0000_0000) + 64'h8000_0000) >> 32;
      return r[31:0] ^ 32'h8000_0000;
   endfunction

   // curve position for a query time under the current shadow state
   function automatic curve_pos_type eval_curve(logic [31:0] qt);
      curve_pos_type res;
      logic [63:0] iv, t, q, rem, u, v, w0v, w2v, w3v;
      logic [63:0] w [4];
      logic [31:0] px [4], py [4], pz [4];
      int          n, seg;
      n = (pt_count > NPTS) ? NPTS : pt_count;
      res = '{x: '0, y: '0, z: '0, seg: '0};
      if (n == 0) return res;
      if (n < 4) begin
         res.x = shx[0];
         res.y = shy[0];
         res.z = shz[0];
         return res;
      end
      iv  = (knot_iv == 0) ? 64'd1 : {32'd0, knot_iv};
      t   = {32'd0, qt};
      q   = t / iv;
      seg = (q > n - 4) ? n - 4 : int'(q);
      rem = t - 64'(seg) * iv;
      u   = (rem << 16) / iv;
      if (u > 64'd65536) u = 64'd65536;
      v   = 64'd65536 - u;
      w0v = v * v * v;
      w3v = u * u * u;
      w2v = (64'd1 << 48) + ((3 * u) << 32) + ((3 * u * u) << 16) - 3 * w3v;
      w[0] = (w0v + 64'd196608) / 64'd393216;
      w[2] = (w2v + 64'd196608) / 64'd393216;
      w[3] = (w3v + 64'd196608) / 64'd393216;
      w[1] = (64'd1 << 32) - w[0] - w[2] - w[3];
      for (int k = 0; k < 4; k++) begin
         px[k] = shx[seg + k];
         py[k] = shy[seg + k];
         pz[k] = shz[seg + k];
      end
      res.x   = blend_coord(px, w);
      res.y   = blend_coord(py, w);
      res.z   = blend_coord(pz, w);
      res.seg = 4'(seg);
      return res;
   endfunction

   // random idling on either side, but none in a quiet stretch
   function automatic bit idle_now();
      if (cyc >= 3000 && cyc < 5500) return 1'b0;
      return $urandom_range(0, 99) < 6;
   endfunction

   // request driver
   always @(negedge clock) begin
      spline_req_type it;
      cyc <= cyc + 1;
      if (!reset && (!req_valid || req_fire)) begin
         if (pending_reqs.size() != 0 && !idle_now()) begin
            it = pending_reqs.pop_front();
            req_valid       <= 1'b1;
            req_action      <= it.action;
            req_point_index <= it.idx;
            req_point_x     <= it.px;
            req_point_y     <= it.py;
            req_point_z     <= it.pz;
            req_query_time  <= it.qtime;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      rsp_ready <= !reset && !idle_now();
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      curve_pos_type want;
      req_fire <= req_valid && req_ready;
      if (reset) begin
         knot_iv  = KNOT_RESET;
         pt_count = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_KNOT_INTERVAL) knot_iv = csr_wdata;
            else pt_count = csr_wdata[4:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pos.size() == 0) begin
               $display("%0t: unexpected response x=%h y=%h z=%h seg=%0d", $time,
                        rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_segment_used);
               failed = 1'b1;
            end else begin
               want = expected_pos.pop_front();
               if (rsp_pos_x !== want.x) begin
                  $display("%0t: pos_x expected %h actual %h", $time, want.x, rsp_pos_x);
                  failed = 1'b1;
               end
               if (rsp_pos_y !== want.y) begin
                  $display("%0t: pos_y expected %h actual %h", $time, want.y, rsp_pos_y);
                  failed = 1'b1;
               end
               if (rsp_pos_z !== want.z) begin
                  $display("%0t: pos_z expected %h actual %h", $time, want.z, rsp_pos_z);
                  failed = 1'b1;
               end
               if (rsp_segment_used !== want.seg) begin
                  $display("%0t: segment_used expected %0d actual %0d", $time,
                           want.seg, rsp_segment_used);
                  failed = 1'b1;
               end
            end
         end
         if (req_valid && req_ready) begin
            n_taken <= n_taken + 1;
            if (req_action == ACT_EVAL) begin
               expected_pos = {expected_pos, eval_curve(req_query_time)};
            end else begin
               shx[req_point_index] = req_point_x;
               shy[req_point_index] = req_point_y;
               shz[req_point_index] = req_point_z;
            end
         end
      end
   end

   task automatic add_load(logic [3:0] idx, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      spline_req_type it;
      it = '{action: ACT_LOAD, idx: idx, px: x, py: y, pz: z, qtime: $urandom()};
      pending_reqs = {pending_reqs, it};
      n_queued++;
   endtask

   task automatic add_eval(logic [31:0] qt);
      spline_req_type it;
      it = '{action: ACT_EVAL, idx: 4'($urandom()), px: $urandom(),
             py: $urandom(), pz: $urandom(), qtime: qt};
      pending_reqs = {pending_reqs, it};
      n_queued++;
   endtask

   // wait until every request is taken and every response is back
   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (n_taken != n_queued || expected_pos.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random point coordinate, often small, sometimes extreme
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2, 3, 4: return $urandom();
         default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      endcase
   endfunction

   function automatic logic [31:0] rand_time(logic [31:0] iv, int n);
      logic [63:0] span;
      span = 64'(iv) * 64'(n + 1);
      if (span > 64'hffff_ffff) span = 64'hffff_ffff;
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'hffff_ffff;
         2: return '0;
         3: return 32'(64'(iv) * $urandom_range(0, n));
         default: return 32'($urandom_range(0, 32'(span)));
      endcase
   endfunction

   function automatic logic [31:0] rand_interval();
      case ($urandom_range(0, 7))
         0: return 32'd1;
         1: return 32'hffff_ffff;
         2: return $urandom_range(2, 100);
         3: return KNOT_RESET;
         4: return 32'h0001_0000;
         5: return $urandom();
         default: return $urandom_range(1000, 200000);
      endcase
   endfunction

   // stimulus
   initial begin
      logic [31:0] iv;
      int          n;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no points loaded and count zero
      add_eval(32'd0);
      add_eval(32'hffff_ffff);
      // fill every slot, extremes first
      add_load(4'd0, 32'h7fff_ffff, 32'h8000_0000, 32'd0);
      add_load(4'd1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
      for (int i = 2; i < NPTS; i++) add_load(4'(i), rand_coord(), rand_coord(), rand_coord());
      drain();

      // too few points: first point is returned
      csr_write(CSR_POINT_COUNT, 32'd1);
      add_eval(32'h1234_5678);
      drain();
      csr_write(CSR_POINT_COUNT, 32'd3);
      add_eval(32'd0);
      drain();
      // smallest interval, full count, segment clamps high
      csr_write(CSR_KNOT_INTERVAL, 32'd1);
      csr_write(CSR_POINT_COUNT, 32'd16);
      add_eval(32'd0);
      add_eval(32'd5);
      add_eval(32'd12);
      add_eval(32'hffff_ffff);
      drain();
      // largest interval, exactly four points
      csr_write(CSR_KNOT_INTERVAL, 32'hffff_ffff);
      csr_write(CSR_POINT_COUNT, 32'd4);
      add_eval(32'd0);
      add_eval(32'h8000_0000);
      add_eval(32'hffff_ffff);
      drain();

      // random phases
      for (int ph = 0; ph < 10; ph++) begin
         iv = rand_interval();
         n  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 16);
         csr_write(CSR_KNOT_INTERVAL, iv);
         csr_write(CSR_POINT_COUNT, 32'(n));
         for (int i = 0; i < 125; i++) begin
            if ($urandom_range(0, 3) == 0)
               add_load(4'($urandom()), rand_coord(), rand_coord(), rand_coord());
            else
               add_eval(rand_time(iv, n));
         end
         drain();
      end

      if (!failed) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // run limit
   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
